/* sv/dlr_pkg.sv */
// ----------------------------------------------------------------------------
// dlr_pkg: shared types and constants for the DDA line rasterizer
// Word formats for both channels and the classified command in the queue.
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam int unsigned COORD_W     = 10;
  localparam int unsigned COLOR_W     = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 4'd4;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } dlr_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
    logic               pixel_valid;
  } dlr_out_t;

  // classified command: start requests carry magnitudes, signs and length
  typedef struct packed {
    logic               is_start;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;
    logic               neg_x;
    logic               neg_y;
    logic [COORD_W-1:0] len;
  } dlr_cmd_t;

endpackage

/* sv/dlr_front.sv */
// ----------------------------------------------------------------------------
// dlr_front: request classifier
// Turns an input word into a command: deltas, magnitudes, signs, line length.
// ----------------------------------------------------------------------------
module dlr_front (
  input  dlr_pkg::dlr_in_t  word_i,
  output dlr_pkg::dlr_cmd_t cmd_o
);
  import dlr_pkg::*;

  logic               neg_x, neg_y;
  logic [COORD_W-1:0] adx, ady;

  always_comb begin
    neg_x = word_i.end_x < word_i.start_x;
    neg_y = word_i.end_y < word_i.start_y;
    adx   = neg_x ? (word_i.start_x - word_i.end_x) : (word_i.end_x - word_i.start_x);
    ady   = neg_y ? (word_i.start_y - word_i.end_y) : (word_i.end_y - word_i.start_y);

    cmd_o.is_start = (word_i.req_type == REQ_START);
    cmd_o.x0       = word_i.start_x;
    cmd_o.y0       = word_i.start_y;
    cmd_o.adx      = adx;
    cmd_o.ady      = ady;
    cmd_o.neg_x    = neg_x;
    cmd_o.neg_y    = neg_y;
    cmd_o.len      = (adx >= ady) ? adx : ady;
  end

endmodule

/* sv/dlr_queue.sv */
// ----------------------------------------------------------------------------
// dlr_queue: command queue
// Small FIFO between classifier and stepper; head is visible combinationally.
// ----------------------------------------------------------------------------
module dlr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dlr_pkg::dlr_cmd_t push_cmd_i,
  input  logic              pop_i,
  output dlr_pkg::dlr_cmd_t head_o,
  output logic              valid_o,
  output logic              full_o
);
  import dlr_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  dlr_cmd_t          slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign head_o  = slots_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* sv/dlr_back.sv */
// ----------------------------------------------------------------------------
// dlr_back: line stepper
// Runs commands from the queue: serial divide on start, one add per step,
// and the output register.
// ----------------------------------------------------------------------------
module dlr_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dlr_pkg::dlr_cmd_t             cmd_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_pop_o,
  input  logic [dlr_pkg::COLOR_W-1:0]   color_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dlr_pkg::dlr_out_t             out_word_o
);
  import dlr_pkg::*;

  localparam int unsigned POS_W  = COORD_W + FRAC_BITS + 1;
  localparam int unsigned STEP_W = FRAC_BITS + 2;
  localparam int unsigned QUO_W  = FRAC_BITS + 1;
  localparam int unsigned CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int unsigned LEFT_W = COORD_W + 1;
  localparam logic [POS_W-1:0] HALF = POS_W'(1) << (FRAC_BITS - 1);

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0]          state_q, state_d;
  logic                active_q, active_d;
  logic [LEFT_W-1:0]   left_q, left_d;
  logic [POS_W-1:0]    pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [STEP_W-1:0]   step_x_q, step_x_d, step_y_q, step_y_d;
  logic [COORD_W-1:0]  rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [QUO_W-1:0]    quo_x_q, quo_x_d, quo_y_q, quo_y_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [COORD_W-1:0]  len_q, len_d;
  logic                neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic                out_valid_q, out_valid_d;
  dlr_out_t            out_word_q, out_word_d;

  logic                slot_free;
  logic [COORD_W:0]    trial_x, trial_y;
  logic                ge_x, ge_y;
  logic [POS_W-1:0]    start_x_pos, start_y_pos;

  function automatic logic [COORD_W-1:0] coord_of(input logic [POS_W-1:0] pos);
    logic [COORD_W-1:0] c;
    if (pos[POS_W-1]) begin
      c = '0;
    end else begin
      c = pos[FRAC_BITS +: COORD_W];
    end
    return c;
  endfunction

  function automatic logic [STEP_W-1:0] signed_step(input logic [QUO_W-1:0] q,
                                                     input logic neg);
    logic [STEP_W-1:0] m;
    m = {1'b0, q};
    return neg ? (~m + STEP_W'(1)) : m;
  endfunction

  function automatic dlr_out_t pixel(input logic [POS_W-1:0] px,
                                     input logic [POS_W-1:0] py,
                                     input logic [COLOR_W-1:0] color,
                                     input logic last);
    dlr_out_t w;
    w.pixel_x     = coord_of(px);
    w.pixel_y     = coord_of(py);
    w.pixel_color = color;
    w.last_pixel  = last;
    w.pixel_valid = 1'b1;
    return w;
  endfunction

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // one restoring divide step per cycle for each axis; no shift on the first
  always_comb begin
    trial_x = (cnt_q == '0) ? {1'b0, rem_x_q} : {rem_x_q, 1'b0};
    trial_y = (cnt_q == '0) ? {1'b0, rem_y_q} : {rem_y_q, 1'b0};
    ge_x    = trial_x >= {1'b0, len_q};
    ge_y    = trial_y >= {1'b0, len_q};
    start_x_pos = {1'b0, cmd_i.x0, FRAC_BITS'(0)} | HALF;
    start_y_pos = {1'b0, cmd_i.y0, FRAC_BITS'(0)} | HALF;
  end

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    left_d      = left_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    step_x_d    = step_x_q;
    step_y_d    = step_y_q;
    rem_x_d     = rem_x_q;
    rem_y_d     = rem_y_q;
    quo_x_d     = quo_x_q;
    quo_y_d     = quo_y_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    neg_x_d     = neg_x_q;
    neg_y_d     = neg_y_q;
    cmd_pop_o   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;

    case (state_q)
      ST_RUN: begin
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o = 1'b1;
          if (!cmd_i.is_start) begin
            out_valid_d = 1'b1;
            if (active_q) begin
              pos_x_d    = pos_x_q + {{(POS_W-STEP_W){step_x_q[STEP_W-1]}}, step_x_q};
              pos_y_d    = pos_y_q + {{(POS_W-STEP_W){step_y_q[STEP_W-1]}}, step_y_q};
              left_d     = left_q - LEFT_W'(1);
              active_d   = (left_q != LEFT_W'(1));
              out_word_d = pixel(pos_x_d, pos_y_d, color_i, left_q == LEFT_W'(1));
            end else begin
              out_word_d = '0;
            end
          end else begin
            pos_x_d = start_x_pos;
            pos_y_d = start_y_pos;
            if (cmd_i.len == '0) begin
              step_x_d    = '0;
              step_y_d    = '0;
              left_d      = '0;
              active_d    = 1'b0;
              out_valid_d = 1'b1;
              out_word_d  = pixel(start_x_pos, start_y_pos, color_i, 1'b1);
            end else begin
              rem_x_d  = cmd_i.adx;
              rem_y_d  = cmd_i.ady;
              quo_x_d  = '0;
              quo_y_d  = '0;
              cnt_d    = '0;
              len_d    = cmd_i.len;
              neg_x_d  = cmd_i.neg_x;
              neg_y_d  = cmd_i.neg_y;
              left_d   = {1'b0, cmd_i.len};
              active_d = 1'b0;
              state_d  = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        rem_x_d = ge_x ? COORD_W'(trial_x - {1'b0, len_q}) : COORD_W'(trial_x);
        rem_y_d = ge_y ? COORD_W'(trial_y - {1'b0, len_q}) : COORD_W'(trial_y);
        quo_x_d = {quo_x_q[QUO_W-2:0], ge_x};
        quo_y_d = {quo_y_q[QUO_W-2:0], ge_y};
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(FRAC_BITS)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        step_x_d = signed_step(quo_x_q, neg_x_q);
        step_y_d = signed_step(quo_y_q, neg_y_q);
        if (slot_free) begin
          active_d    = 1'b1;
          out_valid_d = 1'b1;
          out_word_d  = pixel(pos_x_q, pos_y_q, color_i, 1'b0);
          state_d     = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      active_q    <= 1'b0;
      left_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q    <= pos_x_d;
    pos_y_q    <= pos_y_d;
    step_x_q   <= step_x_d;
    step_y_q   <= step_y_d;
    rem_x_q    <= rem_x_d;
    rem_y_q    <= rem_y_d;
    quo_x_q    <= quo_x_d;
    quo_y_q    <= quo_y_d;
    len_q      <= len_d;
    neg_x_q    <= neg_x_d;
    neg_y_q    <= neg_y_d;
    out_word_q <= out_word_d;
  end

endmodule

/* sv/dda_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// dda_line_rasterizer: DDA line rasterizer
// Start words load two endpoints; step words walk the line one pixel each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i): a word is taken at a
//   clock edge with valid high and stall low. req_type START loads endpoints,
//   STEP advances one pixel. Every word gives exactly one output word.
//   Output channel (out_valid_o / out_stall_i / out_word_o): the output word
//   is registered and held while out_stall_i is high. draw_color is written
//   via cfg_we_i/cfg_wdata_i only while idle (user rule, unchecked); reset 4.
// Timing:
//   A step word passes through the queue and the output register; steps flow
//   one per cycle unless an output stall, a divide or an empty queue holds them.
//   A start word of nonzero length runs a bit-serial divide (ST_DIV) giving a
//   quotient of FRAC_BITS + 1 bits per axis, then forms the increments (ST_FIN).
//   A zero-length start skips the divide and returns its single pixel.
//   The two-entry command queue holds up to two words during the divide.
// Reset clears the queue, the output valid flag and the active line; color
// returns to 4. A stall on the output backs up into the queue, and the input
// stalls once the queue is full.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dlr_pkg::COLOR_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dlr_pkg::dlr_in_t              in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dlr_pkg::dlr_out_t             out_word_o
);
  import dlr_pkg::*;

  logic [COLOR_W-1:0] draw_color_q;
  dlr_cmd_t           front_cmd;
  dlr_cmd_t           head_cmd;
  logic               q_push, q_pop, q_valid, q_full;

  // draw color register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_color_q <= COLOR_RESET;
    end else if (cfg_we_i) begin
      draw_color_q <= cfg_wdata_i;
    end
  end

  // front: classify every incoming word
  dlr_front u_front (
    .word_i (in_word_i),
    .cmd_o  (front_cmd)
  );

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  // queue decouples intake from the stepper
  dlr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (front_cmd),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .valid_o    (q_valid),
    .full_o     (q_full)
  );

  // back: divide on start, accumulate on step, hold result for the receiver
  dlr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .color_i     (draw_color_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef NO_ASSERTIONS
  // a full queue always presents a command
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> q_valid)
    else $error("queue full with no head");

  // an invalid pixel carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.pixel_valid) |->
      (out_word_o.pixel_x == '0 && out_word_o.pixel_y == '0 &&
       out_word_o.pixel_color == '0 && !out_word_o.last_pixel))
    else $error("invalid pixel with nonzero fields");

  // last flag only on a real pixel
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.last_pixel) |-> out_word_o.pixel_valid)
    else $error("last set on invalid pixel");

  // color register takes the written value
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (draw_color_q == $past(cfg_wdata_i)))
    else $error("draw color not updated");
`endif

endmodule
